>>> src/ccp_pkg.sv
// shared types and constants for the column crack partition block
package ccp_pkg;

  localparam int IDX_W   = 12;
  localparam int POS_W   = 13;
  localparam int FIELD_W = 32;
  localparam int ROWID_W = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CRACK = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

endpackage

>>> src/column_crack_partition_core.sv
// column store with write, read and in-place two-cursor crack around a pivot
// write, no-operation, out-of-range read and empty-range crack: answered straight from the idle state
// read: passes through a wait state for the registered ram read
// crack: each cursor step costs one ram read and an evaluation state, and a swap costs
//   two ram writes on the single write port
// reset clears the sequencer and the output valid flag; store contents stay undefined
module column_crack_partition_core #(
  parameter int DEPTH     = 4096,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          opcode,
  input  logic [ccp_pkg::IDX_W-1:0]           start_index,
  input  logic [ccp_pkg::IDX_W-1:0]           end_index,
  input  logic signed [ccp_pkg::FIELD_W-1:0]  entry_key,
  input  logic signed [ccp_pkg::ROWID_W-1:0]  entry_rowid,
  input  logic signed [ccp_pkg::FIELD_W-1:0]  pivot_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ccp_pkg::FIELD_W-1:0]  read_key,
  output logic signed [ccp_pkg::ROWID_W-1:0]  read_rowid,
  output logic [ccp_pkg::POS_W-1:0]           split_position
);

  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W  = KEY_WIDTH + ccp_pkg::ROWID_W;
  localparam int IDX_SPAN = 1 << ccp_pkg::IDX_W;
  localparam int LAST_INT = (DEPTH > IDX_SPAN) ? (IDX_SPAN - 1) : (DEPTH - 1);
  localparam logic [ccp_pkg::IDX_W-1:0] LAST = ccp_pkg::IDX_W'(LAST_INT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_LD_LO,
    S_LD_HI,
    S_EVAL,
    S_SWAP,
    S_FIN_RD,
    S_FIN
  } state_t;

  state_t                       state;
  logic [ccp_pkg::IDX_W-1:0]    lower;
  logic [ccp_pkg::IDX_W-1:0]    upper;
  logic signed [KEY_WIDTH-1:0]  pivot;
  logic signed [KEY_WIDTH-1:0]  lo_key;
  logic signed [KEY_WIDTH-1:0]  up_key;
  logic [ccp_pkg::ROWID_W-1:0]  lo_row;
  logic [ccp_pkg::ROWID_W-1:0]  up_row;
  logic                         reload_hi;

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [ENTRY_W-1:0]           ram_wdata;
  logic                         ram_re;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [ENTRY_W-1:0]           ram_rdata;

  logic                         accept;
  ccp_pkg::opcode_t             op;
  logic                         addr_ok;
  logic [ccp_pkg::IDX_W-1:0]    hi_clamp;
  logic signed [KEY_WIDTH-1:0]  rd_key;
  logic [ccp_pkg::ROWID_W-1:0]  rd_row;
  logic [ccp_pkg::IDX_W-1:0]    lower_inc;
  logic [ccp_pkg::IDX_W-1:0]    upper_dec;
  logic                         lbig;
  logic                         usmall;
  logic                         swap_more;

  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign accept    = in_valid && !in_stall;
  assign op        = ccp_pkg::opcode_t'(opcode);
  assign addr_ok   = start_index <= LAST;
  assign hi_clamp  = (end_index > LAST) ? LAST : end_index;
  assign rd_key    = ram_rdata[ENTRY_W-1 -: KEY_WIDTH];
  assign rd_row    = ram_rdata[ccp_pkg::ROWID_W-1:0];
  assign lower_inc = lower + 1'b1;
  assign upper_dec = upper - 1'b1;
  assign lbig      = lo_key > pivot;
  assign usmall    = !(up_key > pivot);
  assign swap_more = lower_inc < upper_dec;

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(lower);
    ram_wdata = {up_key, up_row};
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(lower);
    unique case (state)
      S_IDLE: begin
        ram_waddr = ADDR_W'(start_index);
        ram_wdata = {KEY_WIDTH'(entry_key), entry_rowid};
        ram_raddr = ADDR_W'(start_index);
        if (accept) begin
          unique case (op)
            ccp_pkg::OP_WRITE: ram_we = addr_ok;
            ccp_pkg::OP_READ:  ram_re = addr_ok;
            ccp_pkg::OP_CRACK: ram_re = start_index < hi_clamp;
            ccp_pkg::OP_NOP:   ram_re = 1'b0;
          endcase
        end
      end
      S_LD_LO: begin
        ram_re    = reload_hi;
        ram_raddr = ADDR_W'(upper);
      end
      S_EVAL: begin
        if (lbig && usmall) begin
          ram_we = 1'b1;
        end else if (!lbig) begin
          ram_re    = lower_inc < upper;
          ram_raddr = ADDR_W'(lower_inc);
        end else begin
          ram_re    = lower < upper_dec;
          ram_raddr = ADDR_W'(upper_dec);
        end
      end
      S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(upper);
        ram_wdata = {lo_key, lo_row};
        ram_re    = swap_more;
        ram_raddr = ADDR_W'(lower_inc);
      end
      S_FIN_RD: begin
        ram_re = 1'b1;
      end
      S_RD_WAIT, S_LD_HI, S_FIN: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      reload_hi <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            read_key       <= '0;
            read_rowid     <= '0;
            split_position <= '0;
            lower          <= start_index;
            upper          <= hi_clamp;
            pivot          <= KEY_WIDTH'(pivot_value);
            reload_hi      <= 1'b1;
            unique case (op)
              ccp_pkg::OP_READ: begin
                if (addr_ok) begin
                  state <= S_RD_WAIT;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              ccp_pkg::OP_CRACK: begin
                if (start_index > hi_clamp) begin
                  split_position <= ccp_pkg::POS_W'(start_index) + 1'b1;
                  out_valid      <= 1'b1;
                end else if (start_index == hi_clamp) begin
                  state <= S_FIN_RD;
                end else begin
                  state <= S_LD_LO;
                end
              end
              ccp_pkg::OP_WRITE, ccp_pkg::OP_NOP: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          read_key   <= ccp_pkg::FIELD_W'(rd_key);
          read_rowid <= rd_row;
          out_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        S_LD_LO: begin
          lo_key <= rd_key;
          lo_row <= rd_row;
          state  <= reload_hi ? S_LD_HI : S_EVAL;
        end
        S_LD_HI: begin
          up_key <= rd_key;
          up_row <= rd_row;
          state  <= S_EVAL;
        end
        S_EVAL: begin
          if (lbig && usmall) begin
            state <= S_SWAP;
          end else if (!lbig) begin
            lower     <= lower_inc;
            reload_hi <= 1'b0;
            state     <= (lower_inc < upper) ? S_LD_LO : S_FIN_RD;
          end else begin
            upper <= upper_dec;
            state <= (lower < upper_dec) ? S_LD_HI : S_FIN_RD;
          end
        end
        S_SWAP: begin
          lower     <= lower_inc;
          upper     <= upper_dec;
          reload_hi <= 1'b1;
          state     <= swap_more ? S_LD_LO : S_FIN_RD;
        end
        S_FIN_RD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (rd_key > pivot) begin
            split_position <= ccp_pkg::POS_W'(lower);
          end else begin
            split_position <= ccp_pkg::POS_W'(lower) + 1'b1;
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ccp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> src/ccp_ram.sv
// generic single write port, single read port ram with registered read
module ccp_ram #(
  parameter  int WIDTH  = 64,
  parameter  int DEPTH  = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [ADDR_W-1:0]        raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
